/* sv/ellrast_pkg.sv */
// ellrast_pkg: shared types, constants and the control store of the ellipse rasterizer.
// Holds the command and dot request formats, the control word layout and the ROM contents.
// No dependencies.
package ellrast_pkg;

    // Geometry and field widths
    localparam int RADIUS_BITS = 10;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 16;
    localparam int SQ_W        = 2 * RADIUS_BITS;       // rx^2, ry^2
    localparam int X_W         = RADIUS_BITS + 1;       // cur_x, unsigned
    localparam int Y_W         = RADIUS_BITS + 2;       // cur_y, signed
    localparam int STEP_W      = 3 * RADIUS_BITS + 3;   // dx, dy, signed
    localparam int MUL_W       = 2 * RADIUS_BITS + 4;   // multiplier operand, signed
    localparam int DEC_W       = 2 * MUL_W;             // decision and product, signed
    localparam int PC_W        = 6;

    // Command modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Command request
    typedef struct packed {
        logic                   mode;
        logic [COORD_W-1:0]     center_col;
        logic [COORD_W-1:0]     center_row;
        logic [RADIUS_BITS-1:0] radius_x;
        logic [RADIUS_BITS-1:0] radius_y;
        logic [COLOR_W-1:0]     color;
    } cmd_t;

    // Dot request
    typedef struct packed {
        logic [COORD_W-1:0] dot_col;
        logic [COORD_W-1:0] dot_row;
        logic [COLOR_W-1:0] dot_color;
        logic               last_dot;
        logic               ellipse_done;
    } dot_t;

    // Control word fields
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RXRX,
        MUL_RYRY,
        MUL_RX2_RY,
        MUL_TT,
        MUL_RY2_P,
        MUL_UU,
        MUL_RX2_P,
        MUL_RX2_RY2
    } mul_op_t;

    typedef enum logic [1:0] {
        SQ_NONE,
        SQ_RX2,
        SQ_RY2
    } sq_wr_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        SRC_P,
        SRC_DX,
        SRC_DY,
        SRC_RX2,
        SRC_RY2
    } acc_src_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_D_NEG,
        JC_D_POS,
        JC_DX_LT_DY,
        JC_R2
    } jmp_cond_t;

    // Dot order within a run: (+x,+y), (-x,+y), (+x,-y), (-x,-y)
    typedef enum logic [1:0] {
        Q_PP,
        Q_NP,
        Q_PN,
        Q_NN
    } quad_t;

    typedef struct packed {
        mul_op_t           mul;
        sq_wr_t            sq;
        acc_op_t           acc;
        acc_src_t          src;
        logic [1:0]        sh;
        logic              init_pt;
        logic              inc_x;
        logic              dec_y;
        logic              set_r2;
        logic              latch_pt;
        logic              emit;
        quad_t             quad;
        logic              fin;
        logic              chk_done;
        jmp_cond_t         cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    // Microprogram entry points
    localparam logic [PC_W-1:0] UA_LOAD   = 6'd0;
    localparam logic [PC_W-1:0] UA_LD_R2  = 6'd6;
    localparam logic [PC_W-1:0] UA_EXIT   = 6'd12;
    localparam logic [PC_W-1:0] UA_STEP   = 6'd13;
    localparam logic [PC_W-1:0] UA_R1_POS = 6'd15;
    localparam logic [PC_W-1:0] UA_R1_NEG = 6'd19;
    localparam logic [PC_W-1:0] UA_R1_CHK = 6'd21;
    localparam logic [PC_W-1:0] UA_ST_R2  = 6'd22;
    localparam logic [PC_W-1:0] UA_R2     = 6'd28;
    localparam logic [PC_W-1:0] UA_R2_POS = 6'd33;
    localparam logic [PC_W-1:0] UA_EMIT   = 6'd35;

    // Region 2 setup: d = ry2*(2x+1)^2 + 4*rx2*(y-1)^2 - 4*rx2*ry2
    function automatic ucode_t entry_word(input logic [2:0] k, input logic [PC_W-1:0] ret);
        ucode_t w;
        w = '0;
        case (k)
            3'd0: w.mul = MUL_TT;
            3'd1: w.mul = MUL_RY2_P;
            3'd2:
            begin
                w.acc = ACC_LOAD;
                w.src = SRC_P;
                w.mul = MUL_UU;
            end
            3'd3: w.mul = MUL_RX2_P;
            3'd4:
            begin
                w.acc = ACC_ADD;
                w.src = SRC_P;
                w.sh  = 2'd2;
                w.mul = MUL_RX2_RY2;
            end
            default:
            begin
                w.acc    = ACC_SUB;
                w.src    = SRC_P;
                w.sh     = 2'd2;
                w.set_r2 = 1'b1;
                w.cond   = JC_ALWAYS;
                w.target = ret;
            end
        endcase
        return w;
    endfunction

    // Control store
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t          w;
        logic [PC_W-1:0] off_ld;
        logic [PC_W-1:0] off_st;
        w      = '0;
        off_ld = addr - UA_LD_R2;
        off_st = addr - UA_ST_R2;
        if (addr >= UA_LD_R2 && addr < UA_EXIT)
        begin
            w = entry_word(off_ld[2:0], UA_EXIT);
        end
        else if (addr >= UA_ST_R2 && addr < UA_R2)
        begin
            w = entry_word(off_st[2:0], UA_EMIT);
        end
        else
        begin
            case (addr)
                // load: squares, start point, region 1 decision
                UA_LOAD:     w.mul = MUL_RXRX;
                UA_LOAD + PC_W'(1):
                begin
                    w.mul = MUL_RYRY;
                    w.sq  = SQ_RX2;
                end
                UA_LOAD + PC_W'(2):
                begin
                    w.sq  = SQ_RY2;
                    w.mul = MUL_RX2_RY;
                end
                UA_LOAD + PC_W'(3):
                begin
                    w.init_pt = 1'b1;
                    w.acc     = ACC_LOAD;
                    w.src     = SRC_RY2;
                    w.sh      = 2'd2;
                end
                UA_LOAD + PC_W'(4):
                begin
                    w.acc = ACC_SUB;
                    w.src = SRC_P;
                    w.sh  = 2'd2;
                end
                UA_LOAD + PC_W'(5):
                begin
                    w.acc    = ACC_ADD;
                    w.src    = SRC_RX2;
                    w.cond   = JC_DX_LT_DY;
                    w.target = UA_EXIT;
                end
                UA_EXIT:     w.fin = 1'b1;
                // step: capture point, pick region
                UA_STEP:
                begin
                    w.latch_pt = 1'b1;
                    w.cond     = JC_R2;
                    w.target   = UA_R2;
                end
                UA_STEP + PC_W'(1):
                begin
                    w.inc_x  = 1'b1;
                    w.cond   = JC_D_NEG;
                    w.target = UA_R1_NEG;
                end
                // region 1, d >= 0
                UA_R1_POS:   w.dec_y = 1'b1;
                UA_R1_POS + PC_W'(1):
                begin
                    w.acc = ACC_ADD;
                    w.src = SRC_DX;
                    w.sh  = 2'd2;
                end
                UA_R1_POS + PC_W'(2):
                begin
                    w.acc = ACC_SUB;
                    w.src = SRC_DY;
                    w.sh  = 2'd2;
                end
                UA_R1_POS + PC_W'(3):
                begin
                    w.acc    = ACC_ADD;
                    w.src    = SRC_RY2;
                    w.sh     = 2'd2;
                    w.cond   = JC_ALWAYS;
                    w.target = UA_R1_CHK;
                end
                // region 1, d < 0
                UA_R1_NEG:
                begin
                    w.acc = ACC_ADD;
                    w.src = SRC_DX;
                    w.sh  = 2'd2;
                end
                UA_R1_NEG + PC_W'(1):
                begin
                    w.acc = ACC_ADD;
                    w.src = SRC_RY2;
                    w.sh  = 2'd2;
                end
                UA_R1_CHK:
                begin
                    w.cond   = JC_DX_LT_DY;
                    w.target = UA_EMIT;
                end
                // region 2, d <= 0
                UA_R2:
                begin
                    w.dec_y  = 1'b1;
                    w.cond   = JC_D_POS;
                    w.target = UA_R2_POS;
                end
                UA_R2 + PC_W'(1):   w.inc_x = 1'b1;
                UA_R2 + PC_W'(2):
                begin
                    w.acc = ACC_ADD;
                    w.src = SRC_DX;
                    w.sh  = 2'd2;
                end
                UA_R2 + PC_W'(3):
                begin
                    w.acc = ACC_SUB;
                    w.src = SRC_DY;
                    w.sh  = 2'd2;
                end
                UA_R2 + PC_W'(4):
                begin
                    w.acc    = ACC_ADD;
                    w.src    = SRC_RX2;
                    w.sh     = 2'd2;
                    w.cond   = JC_ALWAYS;
                    w.target = UA_EMIT;
                end
                // region 2, d > 0
                UA_R2_POS:
                begin
                    w.acc = ACC_ADD;
                    w.src = SRC_RX2;
                    w.sh  = 2'd2;
                end
                UA_R2_POS + PC_W'(1):
                begin
                    w.acc = ACC_SUB;
                    w.src = SRC_DY;
                    w.sh  = 2'd2;
                end
                // four symmetric dots
                UA_EMIT:
                begin
                    w.emit = 1'b1;
                    w.quad = Q_PP;
                end
                UA_EMIT + PC_W'(1):
                begin
                    w.emit = 1'b1;
                    w.quad = Q_NP;
                end
                UA_EMIT + PC_W'(2):
                begin
                    w.emit = 1'b1;
                    w.quad = Q_PN;
                end
                UA_EMIT + PC_W'(3):
                begin
                    w.emit     = 1'b1;
                    w.quad     = Q_NN;
                    w.chk_done = 1'b1;
                    w.fin      = 1'b1;
                end
                default:     w.fin = 1'b1;
            endcase
        end
        return w;
    endfunction

endpackage

/* sv/ellipse_rasterizer.sv */
// ellipse_rasterizer: midpoint ellipse rasterizer driven by a microcoded sequencer.
// Depends on ellrast_pkg (request types, widths, control store).

// A load command latches center, radii and color and sets up region 1, or region 2 at
// once when a radius is zero; it produces no dots and holds off commands until done.
// Each step command produces four dots, (+x,+y), (-x,+y), (+x,-y), (-x,-y), with
// last_dot on the fourth and ellipse_done on all four of the final run. How long a
// step runs depends on its region and branch and on the dot port; the microprogram
// issues one operation per control word to a single multiplier and one 48-bit
// accumulator, then one dot per cycle through the output register while dot_stall
// is low. A step with no ellipse in progress is accepted and produces nothing. A load
// while an ellipse is running abandons it.
module ellipse_rasterizer
    import ellrast_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic dot_valid,
    input  logic dot_stall,
    output dot_t dot
);

    // Control registers
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            run_reg, run_next;
    logic            busy_reg, busy_next;
    logic            r2_reg, r2_next;
    logic            dot_valid_reg, dot_valid_next;

    // Datapath registers
    logic [RADIUS_BITS-1:0]  rx_reg, rx_next;
    logic [RADIUS_BITS-1:0]  ry_reg, ry_next;
    logic [SQ_W-1:0]         rx2_reg, rx2_next;
    logic [SQ_W-1:0]         ry2_reg, ry2_next;
    logic signed [DEC_W-1:0] p_reg, p_next;
    logic signed [DEC_W-1:0] dec_reg, dec_next;
    logic signed [STEP_W-1:0] dx_reg, dx_next;
    logic signed [STEP_W-1:0] dy_reg, dy_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic signed [Y_W-1:0]   y_reg, y_next;
    logic [X_W-1:0]          px_reg, px_next;
    logic [Y_W-2:0]          py_reg, py_next;
    logic [COORD_W-1:0]      ccol_reg, ccol_next;
    logic [COORD_W-1:0]      crow_reg, crow_next;
    logic [COLOR_W-1:0]      color_reg, color_next;
    dot_t                    dot_reg, dot_next;

    ucode_t                  cw;
    logic                    cmd_accept;
    logic                    slot_free;
    logic                    adv;
    logic                    taken;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [DEC_W-1:0] mul_prod;
    logic signed [DEC_W-1:0] acc_src_val, acc_term;
    logic signed [Y_W:0]     u_val;
    logic [COORD_W-1:0]      px_ext, py_ext;

    assign cw         = ucode_rom(pc_reg);
    assign cmd_stall  = run_reg;
    assign cmd_accept = cmd_valid && !run_reg;
    assign slot_free  = !dot_valid_reg || !dot_stall;
    // an emit word holds until the output register can take the dot
    assign adv        = run_reg && !(cw.emit && !slot_free);

    assign dot_valid  = dot_valid_reg;
    assign dot        = dot_reg;

    // Multiplier operand select
    assign u_val = {y_reg[Y_W-1], y_reg} - (Y_W+1)'(1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cw.mul)
            MUL_RXRX:
            begin
                mul_a = MUL_W'(rx_reg);
                mul_b = MUL_W'(rx_reg);
            end
            MUL_RYRY:
            begin
                mul_a = MUL_W'(ry_reg);
                mul_b = MUL_W'(ry_reg);
            end
            MUL_RX2_RY:
            begin
                mul_a = MUL_W'(rx2_reg);
                mul_b = MUL_W'(ry_reg);
            end
            MUL_TT:
            begin
                mul_a = MUL_W'({x_reg, 1'b1});
                mul_b = MUL_W'({x_reg, 1'b1});
            end
            MUL_RY2_P:
            begin
                mul_a = MUL_W'(ry2_reg);
                mul_b = p_reg[MUL_W-1:0];
            end
            MUL_UU:
            begin
                mul_a = MUL_W'(u_val);
                mul_b = MUL_W'(u_val);
            end
            MUL_RX2_P:
            begin
                mul_a = MUL_W'(rx2_reg);
                mul_b = p_reg[MUL_W-1:0];
            end
            MUL_RX2_RY2:
            begin
                mul_a = MUL_W'(rx2_reg);
                mul_b = MUL_W'(ry2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Accumulator operand select and scaling
    always_comb
    begin
        case (cw.src)
            SRC_P:   acc_src_val = p_reg;
            SRC_DX:  acc_src_val = DEC_W'(dx_reg);
            SRC_DY:  acc_src_val = DEC_W'(dy_reg);
            SRC_RX2: acc_src_val = DEC_W'(rx2_reg);
            SRC_RY2: acc_src_val = DEC_W'(ry2_reg);
            default: acc_src_val = '0;
        endcase
    end

    assign acc_term = acc_src_val <<< cw.sh;

    // Branch condition
    always_comb
    begin
        case (cw.cond)
            JC_ALWAYS:   taken = 1'b1;
            JC_D_NEG:    taken = dec_reg < 0;
            JC_D_POS:    taken = dec_reg > 0;
            JC_DX_LT_DY: taken = dx_reg < dy_reg;
            JC_R2:       taken = r2_reg;
            default:     taken = 1'b0;
        endcase
    end

    assign px_ext = COORD_W'(px_reg);
    assign py_ext = COORD_W'(py_reg);

    // Next-state logic: dispatch, microcode execution, dot output
    always_comb
    begin
        pc_next        = pc_reg;
        run_next       = run_reg;
        busy_next      = busy_reg;
        r2_next        = r2_reg;
        dot_valid_next = dot_valid_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rx2_next       = rx2_reg;
        ry2_next       = ry2_reg;
        p_next         = p_reg;
        dec_next       = dec_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ccol_next      = ccol_reg;
        crow_next      = crow_reg;
        color_next     = color_reg;
        dot_next       = dot_reg;

        // output register drains when taken
        if (dot_valid_reg && !dot_stall)
        begin
            dot_valid_next = 1'b0;
        end

        // command dispatch while idle
        if (cmd_accept)
        begin
            if (cmd.mode == MODE_LOAD)
            begin
                ccol_next  = cmd.center_col;
                crow_next  = cmd.center_row;
                color_next = cmd.color;
                rx_next    = cmd.radius_x;
                ry_next    = cmd.radius_y;
                busy_next  = 1'b1;
                run_next   = 1'b1;
                pc_next    = UA_LOAD;
            end
            else if (busy_reg)
            begin
                run_next = 1'b1;
                pc_next  = UA_STEP;
            end
        end

        // execute one control word
        if (adv)
        begin
            if (cw.mul != MUL_NONE)
            begin
                p_next = mul_prod;
            end

            case (cw.sq)
                SQ_RX2:  rx2_next = p_reg[SQ_W-1:0];
                SQ_RY2:  ry2_next = p_reg[SQ_W-1:0];
                default: ;
            endcase

            case (cw.acc)
                ACC_LOAD: dec_next = acc_term;
                ACC_ADD:  dec_next = dec_reg + acc_term;
                ACC_SUB:  dec_next = dec_reg - acc_term;
                default:  ;
            endcase

            if (cw.init_pt)
            begin
                x_next  = '0;
                y_next  = Y_W'(ry_reg);
                dx_next = '0;
                dy_next = STEP_W'(p_reg <<< 1);
                r2_next = 1'b0;
            end
            if (cw.inc_x)
            begin
                x_next  = x_reg + X_W'(1);
                dx_next = dx_reg + (STEP_W'(ry2_reg) << 1);
            end
            if (cw.dec_y)
            begin
                y_next  = y_reg - Y_W'(1);
                dy_next = dy_reg - (STEP_W'(rx2_reg) << 1);
            end
            if (cw.set_r2)
            begin
                r2_next = 1'b1;
            end
            if (cw.latch_pt)
            begin
                px_next = x_reg;
                py_next = y_reg[Y_W-2:0];
            end

            // dot build: bit 0 of the quadrant negates x, bit 1 negates y
            if (cw.emit)
            begin
                dot_valid_next         = 1'b1;
                dot_next.dot_color     = color_reg;
                dot_next.last_dot      = (cw.quad == Q_NN);
                dot_next.ellipse_done  = y_reg[Y_W-1];
                case (cw.quad)
                    Q_PP:
                    begin
                        dot_next.dot_col = ccol_reg + px_ext;
                        dot_next.dot_row = crow_reg + py_ext;
                    end
                    Q_NP:
                    begin
                        dot_next.dot_col = ccol_reg - px_ext;
                        dot_next.dot_row = crow_reg + py_ext;
                    end
                    Q_PN:
                    begin
                        dot_next.dot_col = ccol_reg + px_ext;
                        dot_next.dot_row = crow_reg - py_ext;
                    end
                    default:
                    begin
                        dot_next.dot_col = ccol_reg - px_ext;
                        dot_next.dot_row = crow_reg - py_ext;
                    end
                endcase
            end

            if (cw.chk_done)
            begin
                busy_next = !y_reg[Y_W-1];
            end

            // sequencing
            if (cw.fin)
            begin
                run_next = 1'b0;
            end
            else if (taken)
            begin
                pc_next = cw.target;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            run_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            r2_reg        <= 1'b0;
            dot_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            run_reg       <= run_next;
            busy_reg      <= busy_next;
            r2_reg        <= r2_next;
            dot_valid_reg <= dot_valid_next;
        end
    end

    // Datapath and dot payload
    always_ff @(posedge clk)
    begin
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        rx2_reg   <= rx2_next;
        ry2_reg   <= ry2_next;
        p_reg     <= p_next;
        dec_reg   <= dec_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        ccol_reg  <= ccol_next;
        crow_reg  <= crow_next;
        color_reg <= color_next;
        dot_reg   <= dot_next;
    end

endmodule

/* test/testbench.sv */
// testbench: self-checking bench for ellipse_rasterizer, with a reference predictor
// and a scripted command stream that has random gaps and dot-port stalls.
// Depends on ellrast_pkg and ellipse_rasterizer.
module testbench;
    import ellrast_pkg::*;

    typedef struct {
        cmd_t req;
        bit   drain;    // hold this request back until every predicted dot has come
    } cmd_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic dot_valid;
    logic dot_stall = 1'b0;
    dot_t dot;

    // Command script and the dots predicted for accepted requests
    cmd_item_t cmd_script[$];
    dot_t      pending_dots[$];

    // Predicted ellipse state
    bit                          ell_busy;
    bit                          ell_r2;
    logic [X_W-1:0]              ell_x;
    logic signed [Y_W-1:0]       ell_y;
    logic signed [DEC_W-1:0]     ell_d;
    logic signed [STEP_W-1:0]    ell_dx;
    logic signed [STEP_W-1:0]    ell_dy;
    logic [COORD_W-1:0]          ell_col;
    logic [COORD_W-1:0]          ell_row;
    logic [COLOR_W-1:0]          ell_color;
    logic [SQ_W-1:0]             ell_rx2;
    logic [SQ_W-1:0]             ell_ry2;

    // Handshake bookkeeping
    logic cmd_took = 1'b0;
    logic dot_took = 1'b0;
    int   cmd_wait = 0;
    bit   cmd_quiet = 1'b0;
    int   dot_hold = 0;
    bit   dot_quiet = 1'b0;

    // Statistics
    int   n_total = 0;
    int   n_taken = 0;
    int   n_loads = 0;
    int   n_steps = 0;
    int   n_dots = 0;
    int   n_ellipses = 0;
    int   n_bad = 0;
    dot_t got_dot;

    ellipse_rasterizer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .dot_valid (dot_valid),
        .dot_stall (dot_stall),
        .dot       (dot)
    );

    always #4 clk = ~clk;

    function automatic dot_t make_dot(input logic [COORD_W-1:0] col,
                                      input logic [COORD_W-1:0] row,
                                      input bit last, input bit fin);
        dot_t r;
        r.dot_col      = col;
        r.dot_row      = row;
        r.dot_color    = ell_color;
        r.last_dot     = last;
        r.ellipse_done = fin;
        return r;
    endfunction

    // Advance the midpoint ellipse by one accepted request, queueing the dots it gives
    task automatic trace_ellipse_step(input cmd_t req);
        longint             rx, ry, rx2, ry2, x, y, d, dx, dy, t, u;
        logic [COORD_W-1:0] px, py;
        bit                 chk_r2, fin;
        rx2    = ell_rx2;
        ry2    = ell_ry2;
        x      = ell_x;
        y      = ell_y;
        d      = ell_d;
        dx     = ell_dx;
        dy     = ell_dy;
        chk_r2 = 1'b0;
        if (req.mode == MODE_LOAD)
        begin
            n_loads++;
            rx        = req.radius_x;
            ry        = req.radius_y;
            ell_col   = req.center_col;
            ell_row   = req.center_row;
            ell_color = req.color;
            rx2       = rx * rx;
            ry2       = ry * ry;
            x         = 0;
            y         = ry;
            dx        = 0;
            dy        = 2 * rx2 * ry;
            d         = 4 * ry2 - 4 * rx2 * ry + rx2;
            ell_r2    = 1'b0;
            ell_busy  = 1'b1;
            chk_r2    = 1'b1;
        end
        else
        begin
            n_steps++;
            if (ell_busy)
            begin
                px = x[COORD_W-1:0];
                py = y[COORD_W-1:0];
                if (!ell_r2)
                begin
                    // region 1: x always advances
                    x  = x + 1;
                    dx = dx + 2 * ry2;
                    if (d < 0)
                        d = d + 4 * (dx + ry2);
                    else
                    begin
                        y  = y - 1;
                        dy = dy - 2 * rx2;
                        d  = d + 4 * (dx - dy + ry2);
                    end
                    chk_r2 = 1'b1;
                end
                else
                begin
                    // region 2: y always drops
                    y  = y - 1;
                    dy = dy - 2 * rx2;
                    if (d > 0)
                        d = d + 4 * (rx2 - dy);
                    else
                    begin
                        x  = x + 1;
                        dx = dx + 2 * ry2;
                        d  = d + 4 * (dx - dy + rx2);
                    end
                end
                fin = (y < 0);
                if (fin)
                    ell_busy = 1'b0;
                pending_dots.push_back(make_dot(ell_col + px, ell_row + py, 1'b0, fin));
                pending_dots.push_back(make_dot(ell_col - px, ell_row + py, 1'b0, fin));
                pending_dots.push_back(make_dot(ell_col + px, ell_row - py, 1'b0, fin));
                pending_dots.push_back(make_dot(ell_col - px, ell_row - py, 1'b1, fin));
            end
        end
        // switch to region 2 as soon as dx catches up with dy
        if (chk_r2 && !ell_r2 && dx >= dy)
        begin
            ell_r2 = 1'b1;
            t      = 2 * x + 1;
            u      = y - 1;
            d      = ry2 * t * t + 4 * rx2 * u * u - 4 * rx2 * ry2;
        end
        ell_rx2 = rx2[SQ_W-1:0];
        ell_ry2 = ry2[SQ_W-1:0];
        ell_x   = x[X_W-1:0];
        ell_y   = y[Y_W-1:0];
        ell_d   = d[DEC_W-1:0];
        ell_dx  = dx[STEP_W-1:0];
        ell_dy  = dy[STEP_W-1:0];
    endtask

    task automatic note_mismatch(input string what, input dot_t want, input dot_t seen);
        n_bad++;
        if (n_bad <= 10)
            $display({"MISMATCH %s: expected col=%h row=%h color=%h last=%b done=%b, ",
                      "got col=%h row=%h color=%h last=%b done=%b"},
                     what, want.dot_col, want.dot_row, want.dot_color, want.last_dot,
                     want.ellipse_done, seen.dot_col, seen.dot_row, seen.dot_color,
                     seen.last_dot, seen.ellipse_done);
    endtask

    task automatic queue_cmd(input logic mode, input logic [15:0] col, input logic [15:0] row,
                             input logic [9:0] rx, input logic [9:0] ry,
                             input logic [15:0] color, input bit drain);
        cmd_item_t it;
        it.req.mode       = mode;
        it.req.center_col = col;
        it.req.center_row = row;
        it.req.radius_x   = rx;
        it.req.radius_y   = ry;
        it.req.color      = color;
        it.drain          = drain;
        cmd_script.push_back(it);
    endtask

    // Step requests carry random payload, which the block must ignore
    task automatic queue_steps(input int count);
        repeat (count)
            queue_cmd(MODE_STEP, 16'($urandom), 16'($urandom), 10'($urandom),
                      10'($urandom), 16'($urandom), 1'b0);
    endtask

    // Command driver: presents the next request after its drawn gap
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_took))
        begin
            if (cmd_wait > 0)
            begin
                cmd_wait  <= cmd_wait - 1;
                cmd_valid <= 1'b0;
            end
            else if (cmd_script.size() == 0 ||
                     (cmd_script[0].drain && pending_dots.size() != 0))
                cmd_valid <= 1'b0;
            else
            begin
                cmd       <= cmd_script[0].req;
                cmd_valid <= 1'b1;
                cmd_script.pop_front();
                if ($urandom_range(0, 19) == 0)
                    cmd_quiet <= !cmd_quiet;
                cmd_wait  <= cmd_quiet ? 0 : $urandom_range(0, 13);
            end
        end
    end

    // Dot port stall: a drawn stall after each dot, plus stray stalls while idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (dot_took)
            begin
                if ($urandom_range(0, 19) == 0)
                    dot_quiet = !dot_quiet;
                dot_hold = dot_quiet ? 0 : $urandom_range(0, 13);
            end
            else if (dot_hold > 0)
                dot_hold = dot_hold - 1;
            else if (!dot_valid && !dot_quiet && $urandom_range(0, 7) == 0)
                dot_hold = $urandom_range(1, 13);
            dot_stall <= (dot_hold > 0);
        end
    end

    // Monitor: predicts on each accepted command, checks each accepted dot
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_took <= cmd_valid && !cmd_stall;
            dot_took <= dot_valid && !dot_stall;
            if (cmd_valid && !cmd_stall)
            begin
                trace_ellipse_step(cmd);
                n_taken++;
            end
            if (dot_valid && !dot_stall)
            begin
                n_dots++;
                if (dot.last_dot && dot.ellipse_done)
                    n_ellipses++;
                if (pending_dots.size() == 0)
                    note_mismatch("unexpected dot", '0, dot);
                else
                begin
                    got_dot = pending_dots.pop_front();
                    if (dot.dot_col !== got_dot.dot_col || dot.dot_row !== got_dot.dot_row ||
                        dot.dot_color !== got_dot.dot_color ||
                        dot.last_dot !== got_dot.last_dot ||
                        dot.ellipse_done !== got_dot.ellipse_done)
                        note_mismatch("dot field", got_dot, dot);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int rx, ry, steps, kind, n_real;
        bit drain;

        // Directed: idle steps, zero radii, wrapping centers, large radii, load while busy
        queue_steps(1);
        queue_cmd(MODE_LOAD, 16'h0000, 16'h0000, 10'd0, 10'd0, 16'h0000, 1'b0);
        queue_steps(2);
        queue_cmd(MODE_LOAD, 16'hFFFF, 16'h0000, 10'd5, 10'd0, 16'h1234, 1'b0);
        queue_steps(1);
        queue_cmd(MODE_LOAD, 16'h8000, 16'h7FFF, 10'd0, 10'd3, 16'hFFFF, 1'b0);
        queue_steps(5);
        queue_cmd(MODE_LOAD, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 16'hFFFF, 1'b0);
        queue_steps(3);
        queue_cmd(MODE_LOAD, 16'h0000, 16'hFFFE, 10'd3, 10'd2, 16'h5A5A, 1'b0);
        queue_steps(7);

        // Random: mostly whole small ellipses, some abandoned, some large, some noise
        n_real = 0;
        drain  = 1'b1;
        while (n_real < 180)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                queue_steps($urandom_range(1, 3));
            else if (kind == 1)
            begin
                queue_cmd(MODE_LOAD, 16'($urandom), 16'($urandom), 10'($urandom),
                          10'($urandom), 16'($urandom), drain);
                steps = $urandom_range(1, 6);
                queue_steps(steps);
                n_real += 1 + steps;
            end
            else
            begin
                rx = $urandom_range(0, 10);
                ry = $urandom_range(0, 10);
                queue_cmd(MODE_LOAD, 16'($urandom), 16'($urandom), 10'(rx), 10'(ry),
                          16'($urandom), drain);
                if ($urandom_range(0, 4) == 0)
                    steps = $urandom_range(1, rx + ry + 1);
                else
                    steps = rx + ry + 1 + $urandom_range(0, 1);
                queue_steps(steps);
                n_real += 1 + steps;
            end
            drain = ($urandom_range(0, 7) == 0);
        end
        n_total = cmd_script.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain, then allow for any stray dot
        while (n_taken != n_total || pending_dots.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("Ran %0d loads and %0d steps; %0d dots checked, %0d ellipses traced to the end",
                 n_loads, n_steps, n_dots, n_ellipses);
        $display("%0d mismatches", n_bad);
        if (n_bad == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
